### sv/rgb_to_hsv_pixel_defines.svh
// assertion macros for the rgb to hsv pixel converter
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// property checked on every clock edge outside reset
`define RGBHSV_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("rgb_to_hsv_pixel assertion failed");

// implication checked on every clock edge outside reset
`define RGBHSV_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_pixel implication failed");

`endif

### sv/rgbhsv_pkg.sv
// types, constants and arithmetic helpers for the rgb to hsv pixel converter
package rgbhsv_pkg;

    localparam int FRAC_BITS = 10;
    localparam int QW        = 11;
    localparam int DIV_STEPS = 11;

    localparam logic [10:0] GRAY_LIMIT = 11'd3;
    localparam logic [6:0]  SAT_LIMIT  = 7'd3;
    localparam logic [6:0]  PERCENT    = 7'd100;
    localparam logic [2:0]  OFS_RED    = 3'd0;
    localparam logic [2:0]  OFS_WRAP   = 3'd6;
    localparam logic [2:0]  OFS_GREEN  = 3'd2;
    localparam logic [2:0]  OFS_BLUE   = 3'd4;
    localparam logic signed [10:0] HUE_FULL = 11'sd360;
    localparam logic signed [20:0] DEG_SECTOR = 21'sd60;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] saturation;
        logic [6:0] value;
    } t_pix_out;

    typedef struct packed {
        logic [QW-1:0] rem;
        logic [QW-1:0] num;
        logic [QW-1:0] quo;
    } t_div;

    typedef struct packed {
        t_div          h;
        logic [QW-1:0] hden;
        t_div          s;
        logic [QW-1:0] sden;
        logic          neg;
        logic [2:0]    ofs;
        logic          gray;
        logic [6:0]    val;
    } t_work;

    // floor(c * 1024 / 255)
    function automatic logic [QW-1:0] scale_ch(input logic [7:0] c);
        logic [9:0] t;
        logic [2:0] k;
        t = {c, 2'b00};
        k = 3'(t >= 10'd255) + 3'(t >= 10'd510) + 3'(t >= 10'd765) + 3'(t >= 10'd1020);
        scale_ch = {1'b0, t} + {8'b0, k};
    endfunction

    // one restoring division step
    function automatic t_div div_step(input t_div d, input logic [QW-1:0] den);
        logic [QW:0] sh;
        logic [QW:0] df;
        t_div        o;
        sh    = {d.rem, d.num[QW-1]};
        df    = sh - {1'b0, den};
        o.num = {d.num[QW-2:0], 1'b0};
        if (sh >= {1'b0, den}) begin
            o.rem = df[QW-1:0];
            o.quo = {d.quo[QW-2:0], 1'b1};
        end else begin
            o.rem = sh[QW-1:0];
            o.quo = {d.quo[QW-2:0], 1'b0};
        end
        div_step = o;
    endfunction

endpackage

### sv/rgbhsv_div_stage.sv
// one registered restoring step of the hue and saturation dividers
module rgbhsv_div_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  rgbhsv_pkg::t_work  i_work,
    output logic               o_valid,
    output rgbhsv_pkg::t_work  o_work
);
    import rgbhsv_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;

    always_comb begin
        n_work   = i_work;
        n_work.h = div_step(i_work.h, i_work.hden);
        n_work.s = div_step(i_work.s, i_work.sden);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

### sv/rgb_to_hsv_pixel.sv
// rgb to hsv pixel converter top level
// stages: input, channel scaling, max/min, divider setup, divider steps, output register
// throughput: one item per cycle while i_stall is low, every stage including each divider step is pipelined
// each stage advances when it is empty or its successor advances
// reset clears all valid bits; data registers are not reset
module rgb_to_hsv_pixel (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rgbhsv_pkg::t_pix_in  i_pix,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rgbhsv_pkg::t_pix_out o_pix
);
    import rgbhsv_pkg::*;

    localparam int NST = DIV_STEPS + 5;

    logic [NST-1:0] v;
    logic [NST-1:0] en;

    logic    r_v0, r_v1, r_v2, r_v3, r_vo;
    t_pix_in r_s0;
    logic [QW-1:0] r_qr, r_qg, r_qb;
    logic [QW-1:0] r_mx, r_mn;
    logic signed [QW:0] r_diff;
    logic [2:0] r_ofs;
    t_work r_wk3;
    t_pix_out r_out;

    logic  w_v  [DIV_STEPS+1];
    t_work w_wk [DIV_STEPS+1];

    // stage 2 logic
    logic [QW-1:0] n_mx, n_mn;
    logic signed [QW:0] n_diff;
    logic [2:0] n_ofs;

    // stage 3 logic
    logic [QW-1:0] delta;
    logic [17:0]   vprod;
    logic [16:0]   snum;
    logic [QW:0]   absd;
    t_work         n_wk;

    // output logic
    logic signed [12:0] hq;
    logic signed [14:0] hsum;
    logic signed [20:0] hprod;
    logic signed [10:0] hdeg;
    logic signed [10:0] hwrap;
    t_pix_out           n_out;

    assign w_v[0]  = r_v3;
    assign w_wk[0] = r_wk3;

    always_comb begin
        v[0] = r_v0;
        v[1] = r_v1;
        v[2] = r_v2;
        for (int k = 0; k <= DIV_STEPS; k++) begin
            v[3+k] = w_v[k];
        end
        v[NST-1] = r_vo;
    end

    always_comb begin
        en[NST-1] = !v[NST-1] || !i_stall;
        for (int k = NST-2; k >= 0; k--) begin
            en[k] = !v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_comb begin
        if (r_qr >= r_qg && r_qr >= r_qb) begin
            n_mx   = r_qr;
            n_diff = $signed({1'b0, r_qg}) - $signed({1'b0, r_qb});
            n_ofs  = (r_qg < r_qb) ? OFS_WRAP : OFS_RED;
        end else if (r_qg >= r_qb) begin
            n_mx   = r_qg;
            n_diff = $signed({1'b0, r_qb}) - $signed({1'b0, r_qr});
            n_ofs  = OFS_GREEN;
        end else begin
            n_mx   = r_qb;
            n_diff = $signed({1'b0, r_qr}) - $signed({1'b0, r_qg});
            n_ofs  = OFS_BLUE;
        end
        if (r_qr <= r_qg && r_qr <= r_qb) begin
            n_mn = r_qr;
        end else if (r_qg <= r_qb) begin
            n_mn = r_qg;
        end else begin
            n_mn = r_qb;
        end
    end

    always_comb begin
        delta       = r_mx - r_mn;
        vprod       = {7'b0, r_mx} * {11'b0, PERCENT};
        snum        = 17'({6'b0, delta} * {10'b0, PERCENT});
        absd        = r_diff[QW] ? 12'(-r_diff) : r_diff;
        n_wk.h.rem  = {1'b0, absd[QW-1:1]};
        n_wk.h.num  = {absd[0], {FRAC_BITS{1'b0}}};
        n_wk.h.quo  = '0;
        n_wk.hden   = delta;
        n_wk.s.rem  = {5'b0, snum[16:11]};
        n_wk.s.num  = snum[10:0];
        n_wk.s.quo  = '0;
        n_wk.sden   = r_mx;
        n_wk.neg    = r_diff[QW];
        n_wk.ofs    = r_ofs;
        n_wk.gray   = delta < GRAY_LIMIT;
        n_wk.val    = vprod[16:10];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_vo     <= 1'b0;
        end else begin
            if (en[0]) r_v0 <= i_valid;
            if (en[1]) r_v1 <= r_v0;
            if (en[2]) r_v2 <= r_v1;
            if (en[3]) r_v3 <= r_v2;
            if (en[NST-1]) r_vo <= w_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0 <= i_pix;
        end
        if (en[1]) begin
            r_qr <= scale_ch(r_s0.red);
            r_qg <= scale_ch(r_s0.green);
            r_qb <= scale_ch(r_s0.blue);
        end
        if (en[2]) begin
            r_mx   <= n_mx;
            r_mn   <= n_mn;
            r_diff <= n_diff;
            r_ofs  <= n_ofs;
        end
        if (en[3]) begin
            r_wk3 <= n_wk;
        end
        if (en[NST-1]) begin
            r_out <= n_out;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        rgbhsv_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[4+k]),
            .i_valid (w_v[k]),
            .i_work  (w_wk[k]),
            .o_valid (w_v[k+1]),
            .o_work  (w_wk[k+1])
        );
    end

    always_comb begin
        hq    = w_wk[DIV_STEPS].neg ? -$signed({2'b0, w_wk[DIV_STEPS].h.quo})
                                    :  $signed({2'b0, w_wk[DIV_STEPS].h.quo});
        hsum  = $signed({{2{hq[12]}}, hq})
              + $signed({2'b0, w_wk[DIV_STEPS].ofs, {FRAC_BITS{1'b0}}});
        hprod = $signed({{6{hsum[14]}}, hsum}) * DEG_SECTOR;
        hdeg  = hprod[20:10];
        hwrap = hdeg[10] ? (hdeg + HUE_FULL) : hdeg;
        n_out.value      = w_wk[DIV_STEPS].val;
        n_out.saturation = w_wk[DIV_STEPS].s.quo[6:0];
        n_out.hue        = hwrap[8:0];
        if (w_wk[DIV_STEPS].gray) begin
            n_out.saturation = '0;
            n_out.hue        = '0;
        end else if (w_wk[DIV_STEPS].s.quo[6:0] < SAT_LIMIT) begin
            n_out.hue = '0;
        end
    end

    assign o_valid = r_vo;
    assign o_pix   = r_out;

    `include "rgb_to_hsv_pixel_defines.svh"

    `RGBHSV_IMPLY(a_weak_sat_no_hue, o_valid && o_pix.saturation < SAT_LIMIT, o_pix.hue == '0)
    `RGBHSV_IMPLY(a_out_range, o_valid, o_pix.hue < 9'd360 && o_pix.saturation <= PERCENT)
    `RGBHSV_CHECK(a_empty_out_no_stall, o_valid || !o_stall)

endmodule

### sim/testbench.sv
// self-checking testbench for the rgb to hsv pixel converter
`timescale 1ns / 100ps

module testbench;
    import rgbhsv_pkg::*;

    localparam int N_RANDOM   = 1530;
    localparam int DOG_LIMIT  = 4000;
    localparam int LATENCY    = 16;

    typedef struct {
        t_pix_in  pix;
        logic     typed;
        t_pix_out res;
    } t_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_pix_in  i_pix;
    logic     o_valid;
    logic     i_stall;
    t_pix_out o_pix;

    t_pix_out hsv_expected[$];
    int       mismatches;
    int       dog;
    bit       calm;
    bit       hold_off;

    rgb_to_hsv_pixel DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pix   (i_pix),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pix   (o_pix)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned to_fixed(input logic [7:0] c);
        return (int'(c) * 1024) / 255;
    endfunction

    function automatic t_pix_out hsv_of(input t_pix_in p);
        int r, g, b, mx, mn, delta, sat, hue, h, val;
        t_pix_out o;
        r = to_fixed(p.red);
        g = to_fixed(p.green);
        b = to_fixed(p.blue);
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        sat = 0;
        hue = 0;
        if (delta >= 3) begin
            sat = (100 * delta) / mx;
            if (sat >= 3) begin
                if (mx == r) h = ((g - b) * 1024) / delta + (g < b ? 6 * 1024 : 0);
                else if (mx == g) h = ((b - r) * 1024) / delta + 2 * 1024;
                else h = ((r - g) * 1024) / delta + 4 * 1024;
                h = (h * 60) >>> 10;
                if (h < 0) h += 360;
                hue = h;
            end
        end
        val = (100 * mx) >> 10;
        o.hue = hue[8:0];
        o.saturation = sat[6:0];
        o.value = val[6:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic send_pixel(input t_pix_in p);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= p;
        do @(posedge i_clk); while (o_stall);
        hsv_expected.push_back(hsv_of(p));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge i_clk);
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (hsv_expected.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = hsv_expected.pop_front();
                if (o_pix.hue != want.hue) report_mismatch("hue", o_pix.hue, want.hue);
                if (o_pix.saturation != want.saturation)
                    report_mismatch("saturation", o_pix.saturation, want.saturation);
                if (o_pix.value != want.value)
                    report_mismatch("value", o_pix.value, want.value);
            end
        end
    end

    // receiver stalls
    initial begin
        int n;
        i_stall = 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 15);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) dog <= 0;
        else dog <= dog + 1;
        if (dog >= DOG_LIMIT) begin
            $display("rgb_to_hsv_pixel verification failed");
            $finish;
        end
    end

    initial begin
        t_row    rows[$];
        t_row    row;
        t_pix_in p;
        t_pix_out want;
        int      k;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pix = '0;
        mismatches = 0;
        dog = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        rows = '{
            '{'{8'd0, 8'd0, 8'd0}, 1'b1, '{9'd0, 7'd0, 7'd0}},
            '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{9'd0, 7'd0, 7'd100}},
            '{'{8'd255, 8'd0, 8'd0}, 1'b1, '{9'd0, 7'd100, 7'd100}},
            '{'{8'd0, 8'd255, 8'd0}, 1'b1, '{9'd120, 7'd100, 7'd100}},
            '{'{8'd0, 8'd0, 8'd255}, 1'b1, '{9'd240, 7'd100, 7'd100}},
            '{'{8'd255, 8'd255, 8'd0}, 1'b0, '0},
            '{'{8'd0, 8'd255, 8'd255}, 1'b0, '0},
            '{'{8'd255, 8'd0, 8'd255}, 1'b0, '0},
            '{'{8'd255, 8'd0, 8'd1}, 1'b0, '0},
            '{'{8'd128, 8'd128, 8'd128}, 1'b0, '0},
            '{'{8'd100, 8'd101, 8'd100}, 1'b0, '0},
            '{'{8'd1, 8'd0, 8'd0}, 1'b0, '0},
            '{'{8'd250, 8'd245, 8'd245}, 1'b0, '0},
            '{'{8'd255, 8'd250, 8'd248}, 1'b0, '0},
            '{'{8'd170, 8'd85, 8'd85}, 1'b0, '0},
            '{'{8'd85, 8'd170, 8'd170}, 1'b0, '0},
            '{'{8'd200, 8'd10, 8'd100}, 1'b0, '0},
            '{'{8'd10, 8'd200, 8'd100}, 1'b0, '0},
            '{'{8'd100, 8'd10, 8'd200}, 1'b0, '0},
            '{'{8'd170, 8'd85, 8'd42}, 1'b0, '0}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[j]) begin
            row = rows[j];
            send_pixel(row.pix);
            if (row.typed) begin
                want = hsv_of(row.pix);
                if (want != row.res) report_mismatch("table row", j, 0);
            end
        end
        // sender pause until drained
        wait_drained();

        for (k = 0; k < N_RANDOM; k++) begin
            if (k == 300) hold_off = 1'b1;
            if (k == 700) wait_drained();
            if (k == N_RANDOM - 200) calm = 1'b1;
            p = 24'($urandom);
            case ($urandom_range(0, 3))
                0: p.green = p.red + 8'($urandom_range(0, 3)) - 8'd1;
                1: begin
                    p.green = p.red;
                    p.blue = p.red - 8'($urandom_range(0, 4));
                end
                2: p.blue = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                default: ;
            endcase
            send_pixel(p);
        end
        i_valid <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("rgb_to_hsv_pixel verification clean");
        end else begin
            $display("rgb_to_hsv_pixel verification failed");
        end
        $finish;
    end
endmodule

### files.f
+incdir+sv
sv/rgbhsv_pkg.sv
sv/rgbhsv_div_stage.sv
sv/rgb_to_hsv_pixel.sv
sim/testbench.sv
